// ===== sv/huffman_two_pass_encoder_unit_defines.svh =====
// assertion macros for the huffman encoder unit
// used by the top level; needs clk_i and rst_ni in scope
`ifndef HUFFMAN_TWO_PASS_ENCODER_UNIT_DEFINES_SVH
`define HUFFMAN_TWO_PASS_ENCODER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define HTE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: name");
// next-cycle implication
`define HTE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: name");
`else
`define HTE_ASSERT_IMP(name, ante, cons)
`define HTE_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== sv/hte_pkg.sv =====
// shared constants, types and state codes of the huffman encoder unit
// no dependencies
package hte_pkg;

  localparam int COUNT_BITS   = 32;
  localparam int MAX_CODE_LEN = 48;
  localparam int NSYM         = 256;
  localparam int SYM_W        = $clog2(NSYM);
  localparam int WEIGHT_W     = COUNT_BITS + SYM_W;
  localparam int NODE_DEPTH   = 2 * NSYM;
  localparam int NIDX_W       = $clog2(NODE_DEPTH);
  localparam int NCNT_W       = NIDX_W + 1;
  localparam int DIST_W       = SYM_W + 1;
  localparam int CODE_W       = MAX_CODE_LEN;
  localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
  localparam int CIDX_W       = $clog2(MAX_CODE_LEN);
  localparam int WLEN_W       = NIDX_W;

  localparam logic [WLEN_W-1:0]     MAX_LEN   = WLEN_W'(MAX_CODE_LEN);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic {
    OP_COUNT  = 1'b0,
    OP_ENCODE = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LEAF,
    B_DUMMY,
    B_SCAN,
    B_WR_A,
    B_WR_B,
    B_WR_P,
    B_GEN_RD,
    B_GEN_LEAF,
    B_GEN_WALK,
    B_GEN_WR,
    B_DONE
  } bld_state_e;

  // one tree node as held in the node memory
  typedef struct packed {
    logic                queued;
    logic                leaf;
    logic [SYM_W-1:0]    sym;
    logic [WEIGHT_W-1:0] weight;
    logic                has_par;
    logic [NIDX_W-1:0]   par;
    logic                branch;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } ct_entry_t;

  localparam int CT_W = $bits(ct_entry_t);

  typedef struct packed {
    logic             we;
    logic [SYM_W-1:0] addr;
    ct_entry_t        entry;
  } ct_wr_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] distinct;
  } bld_status_t;

endpackage

// ===== sv/hte_if.sv =====
// valid/ready channel interfaces of the huffman encoder unit
// depends on hte_pkg
interface hte_in_if;
  import hte_pkg::*;
  logic             valid;
  logic             ready;
  op_e              operation;
  logic [SYM_W-1:0] data_byte;
  logic             final_item;
  modport source (output valid, operation, data_byte, final_item, input ready);
  modport sink (input valid, operation, data_byte, final_item, output ready);
endinterface

interface hte_out_if;
  import hte_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic [DIST_W-1:0] distinct_symbols;
  logic              table_result;
  modport source (output valid, code_bits, code_length, distinct_symbols, table_result,
                  input ready);
  modport sink (input valid, code_bits, code_length, distinct_symbols, table_result,
                output ready);
endinterface

// ===== sv/hte_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module hte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read, read returns old data on collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/hte_builder.sv =====
// tree builder: leaf creation, min-pair merging and code walk over the node memory
// depends on hte_pkg and hte_ram
module hte_builder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         ack_i,
  input  logic [hte_pkg::COUNT_BITS-1:0] hist_val_i,
  output logic [hte_pkg::SYM_W-1:0]    hist_addr_o,
  output hte_pkg::ct_wr_t              ct_wr_o,
  output hte_pkg::bld_status_t         status_o
);
  import hte_pkg::*;

  bld_state_e state_q, state_d;
  logic [NCNT_W-1:0] nc_q, nc_d;
  logic [DIST_W-1:0] qc_q, qc_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [SYM_W-1:0]  first_sym_q, first_sym_d;
  logic [SYM_W:0]    s_q, s_d;
  logic              lf_vld_q, lf_vld_d;
  logic [SYM_W-1:0]  lf_sym_q, lf_sym_d;
  logic [NCNT_W-1:0] i_q, i_d;
  logic              rd_vld_q, rd_vld_d;
  logic [NIDX_W-1:0] rd_idx_q, rd_idx_d;
  node_t             m1_q, m1_d, m2_q, m2_d;
  logic [NIDX_W-1:0] m1_idx_q, m1_idx_d, m2_idx_q, m2_idx_d;
  logic              m1_vld_q, m1_vld_d, m2_vld_q, m2_vld_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [WLEN_W-1:0] len_q, len_d;

  logic              nd_we;
  logic [NIDX_W-1:0] nd_wa, nd_ra;
  node_t             nd_wd, nd_rd;
  logic [NODE_W-1:0] nd_rdata;

  hte_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (nd_we),
    .waddr_i (nd_wa),
    .wdata_i (nd_wd),
    .raddr_i (nd_ra),
    .rdata_o (nd_rdata)
  );

  assign nd_rd = node_t'(nd_rdata);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      nc_q     <= '0;
      lf_vld_q <= 1'b0;
      rd_vld_q <= 1'b0;
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      nc_q     <= nc_d;
      lf_vld_q <= lf_vld_d;
      rd_vld_q <= rd_vld_d;
      m1_vld_q <= m1_vld_d;
      m2_vld_q <= m2_vld_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    qc_q        <= qc_d;
    dist_q      <= dist_d;
    first_sym_q <= first_sym_d;
    s_q         <= s_d;
    lf_sym_q    <= lf_sym_d;
    i_q         <= i_d;
    rd_idx_q    <= rd_idx_d;
    m1_q        <= m1_d;
    m2_q        <= m2_d;
    m1_idx_q    <= m1_idx_d;
    m2_idx_q    <= m2_idx_d;
    sym_q       <= sym_d;
    code_q      <= code_d;
    len_q       <= len_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    nc_d        = nc_q;
    qc_d        = qc_q;
    dist_d      = dist_q;
    first_sym_d = first_sym_q;
    s_d         = s_q;
    lf_vld_d    = 1'b0;
    lf_sym_d    = lf_sym_q;
    i_d         = i_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    m1_d        = m1_q;
    m2_d        = m2_q;
    m1_idx_d    = m1_idx_q;
    m2_idx_d    = m2_idx_q;
    m1_vld_d    = m1_vld_q;
    m2_vld_d    = m2_vld_q;
    sym_d       = sym_q;
    code_d      = code_q;
    len_d       = len_q;
    nd_we       = 1'b0;
    nd_wa       = nc_q[NIDX_W-1:0];
    nd_wd       = '0;
    nd_ra       = i_q[NIDX_W-1:0];
    hist_addr_o = s_q[SYM_W-1:0];
    ct_wr_o     = '0;
    status_o    = '0;
    status_o.distinct = dist_q;

    case (state_q)
      B_IDLE: begin
        if (start_i) begin
          s_d     = '0;
          nc_d    = '0;
          dist_d  = '0;
          state_d = B_LEAF;
        end
      end

      // read the histogram in symbol order, one leaf per nonzero count
      B_LEAF: begin
        lf_vld_d = !s_q[SYM_W];
        lf_sym_d = s_q[SYM_W-1:0];
        if (!s_q[SYM_W]) begin
          s_d = s_q + 1'b1;
        end
        if (lf_vld_q && (hist_val_i != '0)) begin
          nd_we         = 1'b1;
          nd_wd.queued  = 1'b1;
          nd_wd.leaf    = 1'b1;
          nd_wd.sym     = lf_sym_q;
          nd_wd.weight  = {{(WEIGHT_W-COUNT_BITS){1'b0}}, hist_val_i};
          nc_d          = nc_q + 1'b1;
          dist_d        = dist_q + 1'b1;
          if (dist_q == '0) begin
            first_sym_d = lf_sym_q;
          end
        end
        if (s_q[SYM_W] && !lf_vld_q) begin
          if (dist_q == '0) begin
            state_d = B_DONE;
          end else if (dist_q == DIST_W'(1)) begin
            state_d = B_DUMMY;
          end else begin
            qc_d     = dist_q;
            i_d      = '0;
            m1_vld_d = 1'b0;
            m2_vld_d = 1'b0;
            state_d  = B_SCAN;
          end
        end
      end

      // lone symbol gets a weight-zero partner
      B_DUMMY: begin
        nd_we        = 1'b1;
        nd_wd.queued = 1'b1;
        nd_wd.leaf   = 1'b1;
        nd_wd.sym    = (first_sym_q == '0) ? SYM_W'(1) : '0;
        nc_d         = nc_q + 1'b1;
        qc_d         = DIST_W'(2);
        i_d          = '0;
        m1_vld_d     = 1'b0;
        m2_vld_d     = 1'b0;
        state_d      = B_SCAN;
      end

      // sweep all nodes, keep the two smallest queued ones, earlier index wins ties
      B_SCAN: begin
        rd_vld_d = (i_q < nc_q);
        rd_idx_d = i_q[NIDX_W-1:0];
        if (i_q < nc_q) begin
          i_d = i_q + 1'b1;
        end
        if (rd_vld_q && nd_rd.queued) begin
          if (!m1_vld_q || (nd_rd.weight < m1_q.weight)) begin
            m2_d     = m1_q;
            m2_idx_d = m1_idx_q;
            m2_vld_d = m1_vld_q;
            m1_d     = nd_rd;
            m1_idx_d = rd_idx_q;
            m1_vld_d = 1'b1;
          end else if (!m2_vld_q || (nd_rd.weight < m2_q.weight)) begin
            m2_d     = nd_rd;
            m2_idx_d = rd_idx_q;
            m2_vld_d = 1'b1;
          end
        end
        if ((i_q >= nc_q) && !rd_vld_q) begin
          state_d = B_WR_A;
        end
      end

      // first pop: 0 branch
      B_WR_A: begin
        nd_we         = 1'b1;
        nd_wa         = m1_idx_q;
        nd_wd         = m1_q;
        nd_wd.queued  = 1'b0;
        nd_wd.has_par = 1'b1;
        nd_wd.par     = nc_q[NIDX_W-1:0];
        nd_wd.branch  = 1'b0;
        state_d       = B_WR_B;
      end

      // second pop: 1 branch
      B_WR_B: begin
        nd_we         = 1'b1;
        nd_wa         = m2_idx_q;
        nd_wd         = m2_q;
        nd_wd.queued  = 1'b0;
        nd_wd.has_par = 1'b1;
        nd_wd.par     = nc_q[NIDX_W-1:0];
        nd_wd.branch  = 1'b1;
        state_d       = B_WR_P;
      end

      // new parent node
      B_WR_P: begin
        nd_we        = 1'b1;
        nd_wd.queued = 1'b1;
        nd_wd.weight = m1_q.weight + m2_q.weight;
        nc_d         = nc_q + 1'b1;
        qc_d         = qc_q - 1'b1;
        i_d          = '0;
        m1_vld_d     = 1'b0;
        m2_vld_d     = 1'b0;
        if (qc_q > DIST_W'(2)) begin
          state_d = B_SCAN;
        end else begin
          state_d = B_GEN_RD;
        end
      end

      // code generation: visit every node, walk leaves up to the root
      B_GEN_RD: begin
        if (i_q == nc_q) begin
          state_d = B_DONE;
        end else begin
          state_d = B_GEN_LEAF;
        end
      end

      B_GEN_LEAF: begin
        if (!nd_rd.leaf) begin
          i_d     = i_q + 1'b1;
          state_d = B_GEN_RD;
        end else begin
          sym_d  = nd_rd.sym;
          code_d = '0;
          len_d  = '0;
          if (nd_rd.has_par) begin
            code_d[0] = nd_rd.branch;
            len_d     = WLEN_W'(1);
            nd_ra     = nd_rd.par;
            state_d   = B_GEN_WALK;
          end else begin
            state_d = B_GEN_WR;
          end
        end
      end

      B_GEN_WALK: begin
        if (nd_rd.has_par) begin
          if (len_q < MAX_LEN) begin
            code_d[len_q[CIDX_W-1:0]] = nd_rd.branch;
          end
          len_d = len_q + 1'b1;
          nd_ra = nd_rd.par;
        end else begin
          state_d = B_GEN_WR;
        end
      end

      // overlong codes are stored as unencodable
      B_GEN_WR: begin
        ct_wr_o.we   = 1'b1;
        ct_wr_o.addr = sym_q;
        if (len_q <= MAX_LEN) begin
          ct_wr_o.entry.bits = code_q;
          ct_wr_o.entry.len  = len_q[LEN_W-1:0];
        end
        i_d     = i_q + 1'b1;
        state_d = B_GEN_RD;
      end

      B_DONE: begin
        status_o.done = 1'b1;
        if (ack_i) begin
          state_d = B_IDLE;
        end
      end

      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/huffman_two_pass_encoder_unit.sv =====
// top level of the two-pass huffman encoder: histogram and code table memories,
// byte front end and result register; depends on hte_pkg, hte_if, hte_ram, hte_builder
//
// Usage:
//  - in_i carries bytes: operation count (first pass) or encode (second pass),
//    final_item marks the last byte of a count pass.
//  - out_o carries results: one per encode byte (code_bits, code_length) and one
//    build result (table_result = 1, distinct_symbols) per completed count pass.
//  - Count and encode bytes are taken one per cycle while in_i.ready is high;
//    the histogram update is a read-modify-write with one-deep forwarding,
//    the encode lookup one table read.
//  - After the final count byte the input stalls for the tree build:
//    leaf creation, then per merge one sweep over all nodes built so far,
//    then code generation, which visits every node and walks each leaf up
//    to the root; the merge sweeps dominate for a full alphabet.
//  - Reset empties the histogram and the code table at once through per-entry
//    valid bits; no clearing pass is needed.
//  - When out_o stalls, one result waits in the output register and one more
//    in the lookup stage, after which in_i.ready drops.
module huffman_two_pass_encoder_unit (
  input logic         clk_i,
  input logic         rst_ni,
  hte_in_if.sink      in_i,
  hte_out_if.source   out_o
);
  import hte_pkg::*;

  `include "huffman_two_pass_encoder_unit_defines.svh"

  logic accept, cnt_acc, enc_acc, out_free;

  // control state
  logic              pass_open_q, pass_open_d;
  logic              build_q, build_d;
  logic              hs_vld_q, hs_fin_q;
  logic [SYM_W-1:0]  hr_addr_q;
  logic              hw_vld_q;
  logic [SYM_W-1:0]  hw_addr_q;
  logic [COUNT_BITS-1:0] hw_data_q;
  logic [NSYM-1:0]   hv_q, hv_d;
  logic [NSYM-1:0]   ctv_q, ctv_d;
  logic              enc_vld_q, enc_vld_d;
  logic [SYM_W-1:0]  enc_addr_q, enc_addr_d;
  logic              out_vld_q, out_vld_d;
  logic [CODE_W-1:0] out_bits_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [DIST_W-1:0] out_dist_q;
  logic              out_tbl_q;

  // histogram memory
  logic [SYM_W-1:0]      hist_ra;
  logic [COUNT_BITS-1:0] hist_rd, hist_val, hist_wd;
  logic                  hist_we;

  // code table memory
  logic [SYM_W-1:0] ct_ra;
  logic [CT_W-1:0]  ct_rdata;
  ct_entry_t        enc_entry;

  // builder
  logic        bld_start, bld_ack;
  logic [SYM_W-1:0] bld_hist_addr;
  ct_wr_t      ct_wr;
  bld_status_t bld_st;

  assign out_free = !out_vld_q || out_o.ready;
  assign in_i.ready = !build_q && !(enc_vld_q && !out_free);
  assign accept  = in_i.valid && in_i.ready;
  assign cnt_acc = accept && (in_i.operation == OP_COUNT);
  assign enc_acc = accept && (in_i.operation == OP_ENCODE);

  // histogram read, forwarding the previous write and masking stale entries
  assign hist_ra  = build_q ? bld_hist_addr : in_i.data_byte;
  assign hist_val = (hw_vld_q && (hw_addr_q == hr_addr_q)) ? hw_data_q :
                    (hv_q[hr_addr_q] ? hist_rd : '0);
  assign hist_we  = hs_vld_q;
  assign hist_wd  = (hist_val == COUNT_MAX) ? hist_val : hist_val + 1'b1;

  hte_ram #(.WIDTH(COUNT_BITS), .DEPTH(NSYM)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hr_addr_q),
    .wdata_i (hist_wd),
    .raddr_i (hist_ra),
    .rdata_o (hist_rd)
  );

  // code table lookup
  assign ct_ra     = enc_acc ? in_i.data_byte : enc_addr_q;
  assign enc_entry = ctv_q[enc_addr_q] ? ct_entry_t'(ct_rdata) : '0;

  hte_ram #(.WIDTH(CT_W), .DEPTH(NSYM)) u_ct_ram (
    .clk_i   (clk_i),
    .we_i    (ct_wr.we),
    .waddr_i (ct_wr.addr),
    .wdata_i (ct_wr.entry),
    .raddr_i (ct_ra),
    .rdata_o (ct_rdata)
  );

  assign bld_start = hs_vld_q && hs_fin_q;
  assign bld_ack   = bld_st.done && out_free;

  hte_builder u_builder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (bld_start),
    .ack_i       (bld_ack),
    .hist_val_i  (hist_val),
    .hist_addr_o (bld_hist_addr),
    .ct_wr_o     (ct_wr),
    .status_o    (bld_st)
  );

  // next-state logic of the front end
  always_comb begin
    pass_open_d = pass_open_q;
    build_d     = build_q;
    hv_d        = hv_q;
    ctv_d       = ctv_q;
    enc_vld_d   = enc_vld_q;
    enc_addr_d  = enc_addr_q;
    out_vld_d   = out_vld_q;

    // pass bookkeeping and histogram valid bits
    if (cnt_acc) begin
      pass_open_d = !in_i.final_item;
      if (in_i.final_item) begin
        build_d = 1'b1;
      end
    end
    if (bld_ack) begin
      build_d = 1'b0;
    end
    if (cnt_acc && !pass_open_q) begin
      hv_d = '0;
    end else if (hist_we) begin
      hv_d[hr_addr_q] = 1'b1;
    end

    // code table valid bits
    if (bld_start) begin
      ctv_d = '0;
    end else if (ct_wr.we) begin
      ctv_d[ct_wr.addr] = 1'b1;
    end

    // lookup stage
    if (enc_acc) begin
      enc_vld_d  = 1'b1;
      enc_addr_d = in_i.data_byte;
    end else if (enc_vld_q && out_free) begin
      enc_vld_d = 1'b0;
    end

    // output register
    if (out_free) begin
      out_vld_d = enc_vld_q || bld_st.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_open_q <= 1'b0;
      build_q     <= 1'b0;
      hs_vld_q    <= 1'b0;
      hs_fin_q    <= 1'b0;
      hw_vld_q    <= 1'b0;
      hv_q        <= '0;
      ctv_q       <= '0;
      enc_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      pass_open_q <= pass_open_d;
      build_q     <= build_d;
      hs_vld_q    <= cnt_acc;
      hs_fin_q    <= cnt_acc && in_i.final_item;
      hw_vld_q    <= hist_we;
      hv_q        <= hv_d;
      ctv_q       <= ctv_d;
      enc_vld_q   <= enc_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hr_addr_q  <= hist_ra;
    hw_addr_q  <= hr_addr_q;
    hw_data_q  <= hist_wd;
    enc_addr_q <= enc_addr_d;
    if (out_free) begin
      if (enc_vld_q) begin
        out_bits_q <= enc_entry.bits;
        out_len_q  <= enc_entry.len;
        out_dist_q <= '0;
        out_tbl_q  <= 1'b0;
      end else begin
        out_bits_q <= '0;
        out_len_q  <= '0;
        out_dist_q <= bld_st.distinct;
        out_tbl_q  <= 1'b1;
      end
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.code_bits        = out_bits_q;
  assign out_o.code_length      = out_len_q;
  assign out_o.distinct_symbols = out_dist_q;
  assign out_o.table_result     = out_tbl_q;

  // checks
  `HTE_ASSERT_IMP(a_no_take_in_build, build_q, !in_i.ready)
  `HTE_ASSERT_NXT(a_lookup_held, enc_vld_q && !out_free, enc_vld_q && $stable(enc_addr_q))
  `HTE_ASSERT_IMP(a_build_alone, bld_st.done, !enc_vld_q && build_q)

endmodule
